### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define TCR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define TCR_NEVER(lbl, cond, msg) \
  `TCR_CHECK(lbl, !(cond), msg)

`endif

### design/tcr_pkg.sv
// types, color kinds and palette constants of the terminal color resolver
`timescale 1ns / 1ps

package tcr_pkg;

  typedef enum logic [1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_DIRECT  = 2'd1,
    KIND_PALETTE = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] color_index;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       is_foreground;
    logic       bold;
  } tcr_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } tcr_out_t;

  localparam logic [23:0] BASE_DARK [16] = '{
    24'h1B1E26, 24'hF2646C, 24'h5CC98A, 24'hE5B567,
    24'h5BA8F7, 24'hC084F0, 24'h4FC1C8, 24'hC5CAD6,
    24'h545A6B, 24'hFF838A, 24'h7AE3A6, 24'hFFCE7F,
    24'h7FBEFF, 24'hD5A1FF, 24'h6EDAE1, 24'hEEF1F7
  };

  localparam logic [23:0] BASE_LIGHT [16] = '{
    24'h2B303B, 24'hC7353F, 24'h2A8C5A, 24'hA1710F,
    24'h1E66C4, 24'h8B45C7, 24'h117D89, 24'h5A6170,
    24'h8C93A3, 24'hE2505A, 24'h38A86E, 24'hC08C22,
    24'h3681E0, 24'hA65FE0, 24'h1E99A6, 24'h2B303B
  };

  localparam logic [23:0] DARK_BG  = 24'h12141A;
  localparam logic [23:0] DARK_FG  = 24'hC5CAD6;
  localparam logic [23:0] LIGHT_BG = 24'hFBFCFE;
  localparam logic [23:0] LIGHT_FG = 24'h2B303B;

  localparam logic [7:0] CUBE_START = 8'd16;
  localparam logic [7:0] GREY_START = 8'd232;

  function automatic logic [7:0] cube_level(input logic [2:0] step);
    logic [7:0] lvl;
    case (step)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

endpackage

### design/tcr_palette.sv
// 256-entry palette lookup: base table, 6x6x6 cube and grey ramp
`timescale 1ns / 1ps

module tcr_palette (
  input  logic [7:0]  idx,
  input  logic        light,
  output logic [23:0] rgb
);
  import tcr_pkg::*;

  logic [7:0] v;
  logic [2:0] r_step;
  logic [2:0] g_step;
  logic [7:0] rem_rg;
  logic [7:0] b_val;
  logic [4:0] grey_i;
  logic [7:0] grey;

  always_comb begin
    v = idx - CUBE_START;
    r_step = 3'((v >= 8'd36)) + 3'((v >= 8'd72)) + 3'((v >= 8'd108))
           + 3'((v >= 8'd144)) + 3'((v >= 8'd180));
    rem_rg = v - 8'd36 * 8'(r_step);
    g_step = 3'((rem_rg >= 8'd6)) + 3'((rem_rg >= 8'd12)) + 3'((rem_rg >= 8'd18))
           + 3'((rem_rg >= 8'd24)) + 3'((rem_rg >= 8'd30));
    b_val = rem_rg - 8'd6 * 8'(g_step);
    grey_i = 5'(idx - GREY_START);
    grey = 8'd8 + {grey_i, 3'b000} + {2'b00, grey_i, 1'b0};

    if (idx < CUBE_START) begin
      rgb = light ? BASE_LIGHT[idx[3:0]] : BASE_DARK[idx[3:0]];
    end else if (idx < GREY_START) begin
      rgb = {cube_level(r_step), cube_level(g_step), cube_level(b_val[2:0])};
    end else begin
      rgb = {grey, grey, grey};
    end
  end

endmodule

### design/terminal_color_resolver.sv
// terminal color resolver top level: input register, color logic, result register
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_stall   tcr_in_t color request
//   out_     output     out_valid/out_stall tcr_out_t resolved rgb
//   cfg_     input      cfg_valid/cfg_ready light_scheme bit
//
// one word per cycle sustained while out_stall is low
// the only path is input register -> color logic -> result register
// synchronous active-low reset empties both stages and clears light_scheme to dark
// out_stall holds the result register; the input register keeps taking words while either
// stage has room, so in_stall rises only when both stages are full and the output is stalled
`timescale 1ns / 1ps
`include "assert_macros.svh"

module terminal_color_resolver (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcr_pkg::tcr_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output tcr_pkg::tcr_out_t out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import tcr_pkg::*;

  logic     light_r;
  logic     s1_valid_r;
  tcr_in_t  s1_word_r;
  logic     out_valid_r;
  tcr_out_t out_word_r;

  logic       adv_out;
  logic       adv_in;
  logic [7:0] pal_idx;
  logic [23:0] pal_rgb;
  logic [23:0] res_nxt;

  tcr_palette u_palette (
    .idx   (pal_idx),
    .light (light_r),
    .rgb   (pal_rgb)
  );

  assign adv_out   = !out_valid_r || !out_stall;
  assign adv_in    = !s1_valid_r || adv_out;
  assign in_stall  = !adv_in;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // bold foreground lifts base colors 0-7 to their bright variants
  always_comb begin
    pal_idx = s1_word_r.color_index;
    if (s1_word_r.bold && s1_word_r.is_foreground && s1_word_r.color_index[7:3] == 5'd0) begin
      pal_idx = {5'd1, s1_word_r.color_index[2:0]};
    end
    case (kind_t'(s1_word_r.func))
      KIND_DIRECT:  res_nxt = {s1_word_r.in_red, s1_word_r.in_green, s1_word_r.in_blue};
      KIND_PALETTE: res_nxt = pal_rgb;
      default: begin
        if (light_r) begin
          res_nxt = s1_word_r.is_foreground ? LIGHT_FG : LIGHT_BG;
        end else begin
          res_nxt = s1_word_r.is_foreground ? DARK_FG : DARK_BG;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        light_r <= cfg_data;
      end
      if (adv_in) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_word_r <= in_word;
    end
    if (adv_out && s1_valid_r) begin
      out_word_r <= res_nxt;
    end
  end

  `TCR_NEVER(a_stall_only_when_full, in_stall && !(s1_valid_r && out_valid_r && out_stall), "input stalled while a stage has room")
  `TCR_CHECK(a_fill_output, s1_valid_r && !out_valid_r |=> out_valid_r, "word in input register did not reach output")
  `TCR_CHECK(a_held_result, out_valid_r && out_stall |=> out_valid_r, "stalled result dropped")
  `TCR_CHECK(a_direct_pass, s1_valid_r && adv_out && s1_word_r.func == KIND_DIRECT |=> out_word_r.out_red == $past(s1_word_r.in_red), "direct red not passed through")

endmodule
